### sv/bmpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BMP pixel stream decoder.
// No dependencies.
package bmpd_pkg;

  localparam logic [31:0] MAX_WIDTH  = 32'd4096;
  localparam logic [31:0] MAX_HEIGHT = 32'd4096;

  // Header byte positions at which a little-endian word is complete
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_BPP_END    = 32'd31;

  localparam logic [31:0] MIN_OFFSET = 32'd32;

  // floor(s / 3) == (s * 683) >> 11 for every sum of three bytes
  localparam logic [9:0] GRAY_RECIP = 10'd683;
  localparam int         GRAY_SHIFT = 11;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXELS = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bmpd_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  gray;
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [2:0]  channel_count;
    logic        last_pixel;
    logic        status;
  } bmpd_out_t;

endpackage

### sv/bmp_pixel_stream_decoder_core.sv
`timescale 1ns / 1ps
// BMP pixel stream decoder: header capture, row walk and pixel result register.
// Depends on bmpd_pkg.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  item     | in        | item_valid / item_ready    | bmpd_in_t  (one file byte)
//  result   | out       | result_valid / result_ready| bmpd_out_t (pixel or error)
//
// One byte is taken per cycle; its result, if any, is in the result register
// on the next cycle. The single result register sets the rate: a new byte is
// taken whenever that register is empty or is being emptied in the same cycle.
// Synchronous reset clears the phase and counters; no clearing pass is needed.
// A stall on the result side holds item_ready low until the result is taken.
module bmp_pixel_stream_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  bmpd_pkg::bmpd_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output bmpd_pkg::bmpd_out_t result
);
  import bmpd_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] header_word, header_word_next;
  logic [31:0] pixel_offset, pixel_offset_next;
  logic [12:0] width_reg, width_reg_next;
  logic [12:0] height_reg, height_reg_next;
  logic        rows_from_top, rows_from_top_next;
  logic [2:0]  channels_reg, channels_reg_next;
  logic [11:0] row_count, row_count_next;
  logic [14:0] row_byte_count, row_byte_count_next;
  logic [11:0] col_count, col_count_next;
  logic [1:0]  pixel_byte, pixel_byte_next;
  logic [7:0]  held_bytes [2];
  logic [7:0]  held_bytes_next [2];

  // State as seen by this byte: start_of_file wipes progress first
  phase_t      c_phase;
  logic [31:0] c_byte_position, c_header_word, c_pixel_offset;
  logic [12:0] c_width, c_height;
  logic        c_from_top;
  logic [2:0]  c_channels;
  logic [11:0] c_row_count, c_col_count;
  logic [14:0] c_row_byte_count;
  logic [1:0]  c_pixel_byte;

  logic [31:0] v, mag;
  logic        offset_ok, width_ok, height_ok, bpp_ok;
  logic [14:0] data_len, row_span;
  logic [15:0] rbc_inc;
  logic [12:0] row_inc, col_inc;
  logic        emit, last;
  logic [7:0]  pr, pg, pb;
  logic [9:0]  rgb_sum;
  logic [19:0] gray_prod;
  logic        accept, load_result;
  bmpd_out_t   result_next;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  always_comb begin
    if (item.start_of_file) begin
      c_phase          = PH_HEADER;
      c_byte_position  = '0;
      c_header_word    = '0;
      c_pixel_offset   = '0;
      c_width          = '0;
      c_height         = '0;
      c_from_top       = 1'b0;
      c_channels       = '0;
      c_row_count      = '0;
      c_col_count      = '0;
      c_row_byte_count = '0;
      c_pixel_byte     = '0;
    end else begin
      c_phase          = phase;
      c_byte_position  = byte_position;
      c_header_word    = header_word;
      c_pixel_offset   = pixel_offset;
      c_width          = width_reg;
      c_height         = height_reg;
      c_from_top       = rows_from_top;
      c_channels       = channels_reg;
      c_row_count      = row_count;
      c_col_count      = col_count;
      c_row_byte_count = row_byte_count;
      c_pixel_byte     = pixel_byte;
    end
  end

  // Header field checks on the word completed by this byte
  assign v         = {item.data_byte, c_header_word[31:8]};
  assign mag       = v[31] ? (~v + 32'd1) : v;
  assign offset_ok = !v[31] && (v >= MIN_OFFSET);
  assign width_ok  = (v >= 32'd1) && (v <= MAX_WIDTH);
  assign height_ok = (mag >= 32'd1) && (mag <= MAX_HEIGHT);
  assign bpp_ok    = !v[31] && ((v[30:3] == 28'd1) || (v[30:3] == 28'd3));

  // Row geometry
  assign data_len = (c_channels == 3'd3) ? ({2'b00, c_width} + {1'b0, c_width, 1'b0})
                                         : {2'b00, c_width};
  assign row_span = (data_len + 15'd3) & ~15'd3;
  assign rbc_inc  = {1'b0, c_row_byte_count} + 16'd1;
  assign row_inc  = {1'b0, c_row_count} + 13'd1;
  assign col_inc  = {1'b0, c_col_count} + 13'd1;

  assign rgb_sum   = {2'b00, pr} + {2'b00, pg} + {2'b00, pb};
  assign gray_prod = rgb_sum * GRAY_RECIP;

  always_comb begin
    phase_next          = c_phase;
    byte_position_next  = c_byte_position;
    header_word_next    = c_header_word;
    pixel_offset_next   = c_pixel_offset;
    width_reg_next      = c_width;
    height_reg_next     = c_height;
    rows_from_top_next  = c_from_top;
    channels_reg_next   = c_channels;
    row_count_next      = c_row_count;
    row_byte_count_next = c_row_byte_count;
    col_count_next      = c_col_count;
    pixel_byte_next     = c_pixel_byte;
    held_bytes_next     = held_bytes;
    emit                = 1'b0;
    last                = 1'b0;
    pr                  = item.data_byte;
    pg                  = item.data_byte;
    pb                  = item.data_byte;
    load_result         = 1'b0;
    result_next         = '0;

    unique case (c_phase)
      PH_HEADER: begin
        header_word_next   = v;
        byte_position_next = c_byte_position + 32'd1;
        if (c_byte_position == POS_OFFSET_END) begin
          pixel_offset_next = offset_ok ? v : '0;
        end else if (c_byte_position == POS_WIDTH_END) begin
          width_reg_next = width_ok ? v[12:0] : '0;
        end else if (c_byte_position == POS_HEIGHT_END) begin
          rows_from_top_next = v[31];
          height_reg_next    = height_ok ? mag[12:0] : '0;
        end else if (c_byte_position == POS_BPP_END) begin
          channels_reg_next = bpp_ok ? v[5:3] : '0;
          if (!bpp_ok || c_width == '0 || c_height == '0 || c_pixel_offset == '0) begin
            phase_next         = PH_ERROR;
            load_result        = 1'b1;
            result_next.status = 1'b1;
          end else begin
            phase_next = PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (c_byte_position < c_pixel_offset) begin
          byte_position_next = c_byte_position + 32'd1;
        end else begin
          if (c_row_byte_count < data_len) begin
            if (c_channels == 3'd1) begin
              emit = 1'b1;
            end else begin
              pixel_byte_next = (c_pixel_byte == 2'd2) ? 2'd0 : c_pixel_byte + 2'd1;
              case (c_pixel_byte)
                2'd0:    held_bytes_next[0] = item.data_byte;
                2'd1:    held_bytes_next[1] = item.data_byte;
                default: begin
                  emit = 1'b1;
                  pg   = held_bytes[1];
                  pb   = held_bytes[0];
                end
              endcase
            end
          end
          if (emit) begin
            last           = (row_inc == c_height) && (col_inc == c_width);
            col_count_next = col_inc[11:0];
            load_result    = 1'b1;
            result_next.red           = pr;
            result_next.green         = pg;
            result_next.blue          = pb;
            result_next.gray          = (c_channels == 3'd1) ? item.data_byte
                                                             : gray_prod[GRAY_SHIFT +: 8];
            result_next.pixel_row     = c_from_top ? c_row_count
                                                   : (c_height[11:0] - 12'd1 - c_row_count);
            result_next.pixel_column  = c_col_count;
            result_next.frame_width   = c_width;
            result_next.frame_height  = c_height;
            result_next.channel_count = c_channels;
            result_next.last_pixel    = last;
            result_next.status        = 1'b0;
            if (last) begin
              phase_next = PH_DONE;
            end
          end
          // Drop padding; wrap to the next row at the padded row size
          row_byte_count_next = rbc_inc[14:0];
          if (rbc_inc >= {1'b0, row_span}) begin
            row_byte_count_next = '0;
            col_count_next      = '0;
            pixel_byte_next     = '0;
            row_count_next      = row_inc[11:0];
            if (row_inc >= c_height) begin
              phase_next = PH_DONE;
            end
          end
        end
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_position  <= '0;
      header_word    <= '0;
      pixel_offset   <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      rows_from_top  <= 1'b0;
      channels_reg   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      col_count      <= '0;
      pixel_byte     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      header_word    <= header_word_next;
      pixel_offset   <= pixel_offset_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      rows_from_top  <= rows_from_top_next;
      channels_reg   <= channels_reg_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
      col_count      <= col_count_next;
      pixel_byte     <= pixel_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes[0] <= held_bytes_next[0];
      held_bytes[1] <= held_bytes_next[1];
    end
  end

  // Result register: refill on accept, drain when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= load_result;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load_result) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |->
      result.frame_width == '0 && result.channel_count == '0 && result.red == '0)
    else $error("error result carries nonzero fields");

  a_pixel_format: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.status |->
      (result.channel_count == 3'd1 || result.channel_count == 3'd3) &&
      result.frame_width != '0 && result.frame_height != '0)
    else $error("pixel result with unaccepted format");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.status |->
      {1'b0, result.pixel_column} < result.frame_width)
    else $error("pixel column beyond image width");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    accept && !item.start_of_file && (phase == PH_DONE || phase == PH_ERROR) |->
      !load_result)
    else $error("result produced after end of image or error");

  a_end_phase: assert property (@(posedge clk) disable iff (rst)
    accept && load_result && result_next.last_pixel |=> phase == PH_DONE)
    else $error("last pixel did not close the image");
`endif

endmodule
